/* src/htw_pkg.sv */
// Shared types, codes and widths for the hashed timer wheel.
// No dependencies; every other file of the block but htw_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package htw_pkg;

	localparam int TIMERS_DEF = 32;
	localparam int SLOTS_DEF  = 256;

	localparam int TIME_W     = 40;
	localparam int PERIOD_W   = 16;
	localparam int SCNT_W     = 9;
	localparam int HANDLE_W   = 5;
	localparam int ID_W       = 5;
	localparam int SEQ_W      = 32;
	localparam int MODE_W     = 2;
	localparam int KIND_W     = 2;
	localparam int S_TDATA_W  = 88;
	localparam int M_TDATA_W  = 48;
	localparam int M_TUSER_W  = 3;
	localparam int CFG_W      = 16;
	localparam int QDEPTH     = 2;

	localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd10;
	localparam logic [SCNT_W-1:0]   SLOTS_RST  = 9'd256;

	localparam logic CFG_PERIOD = 1'b0;
	localparam logic CFG_SLOTS  = 1'b1;

	localparam logic [MODE_W-1:0] MODE_START_REL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_START_ABS = 2'd1;
	localparam logic [MODE_W-1:0] MODE_STOP      = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TICK      = 2'd3;

	typedef enum logic [1:0] {
		OP_START_REL,
		OP_START_ABS,
		OP_STOP,
		OP_TICK
	} htw_op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_STARTED = 2'd0,
		KIND_FIRED   = 2'd1,
		KIND_TICK    = 2'd2,
		KIND_ERROR   = 2'd3
	} htw_kind_t;

	typedef enum logic [4:0] {
		B_IDLE,
		B_START,
		B_SYNC_WAIT,
		B_EXP,
		B_EXP_WAIT,
		B_START_EMIT,
		B_STOP,
		B_STOP_EMIT,
		B_ERR_EMIT,
		B_TICK,
		B_SCAN,
		B_FIRE,
		B_TICK_POST,
		B_ADV_WAIT,
		B_TGT_WAIT,
		B_SWEEP_CHK,
		B_SWEEP_ADV,
		B_TICK_DONE
	} htw_back_state_t;

	typedef enum logic [1:0] {
		D_IDLE,
		D_DIV,
		D_MOD
	} htw_div_state_t;

	typedef struct packed {
		htw_op_t               op;
		logic [TIME_W-1:0]     time_ms;
		logic [TIME_W-1:0]     clock_ms;
		logic [HANDLE_W-1:0]   handle;
		logic                  handle_ok;
	} htw_cmd_t;

	typedef struct packed {
		logic                  start;
		logic                  mod_only;
		logic [TIME_W-1:0]     num;
	} htw_div_req_t;

endpackage

`default_nettype wire

/* src/htw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module htw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/htw_div.sv */
// Slot index unit: (num / period) mod slots, or num mod slots alone, one bit per cycle.
// Depends on htw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module htw_div #(
	parameter int SW = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire htw_pkg::htw_div_req_t           req,
	input  wire logic [htw_pkg::PERIOD_W-1:0]    per,
	input  wire logic [htw_pkg::SCNT_W-1:0]      slots,
	output logic                                 done,
	output logic      [SW-1:0]                   res
);
	import htw_pkg::*;

	htw_div_state_t      state_q, state_nx;
	logic [5:0]          cnt_q;
	logic [TIME_W-1:0]   num_q;
	logic [PERIOD_W:0]   rem_q;
	logic [PERIOD_W:0]   divisor, rem_sh, rem_nx;
	logic                ge, last_bit;

	always_comb begin
		divisor  = (state_q == D_DIV) ? {1'b0, per} : (PERIOD_W + 1)'(slots);
		rem_sh   = {rem_q[PERIOD_W-1:0], num_q[TIME_W-1]};
		ge       = rem_sh >= divisor;
		rem_nx   = ge ? rem_sh - divisor : rem_sh;
		last_bit = cnt_q == 6'(TIME_W - 1);
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			D_IDLE: begin
				if (req.start) begin
					state_nx = req.mod_only ? D_MOD : D_DIV;
				end
			end
			D_DIV: begin
				if (last_bit) state_nx = D_MOD;
			end
			D_MOD: begin
				if (last_bit) state_nx = D_IDLE;
			end
			default: state_nx = D_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == D_MOD) && last_bit;
		res  = SW'(rem_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == D_IDLE) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= last_bit ? 6'd0 : cnt_q + 6'd1;
			end
		end
	end

	// quotient bits collect in num_q; the mod pass then walks that quotient
	always_ff @(posedge clk) begin
		if (state_q == D_IDLE) begin
			if (req.start) begin
				num_q <= req.num;
				rem_q <= '0;
			end
		end else begin
			num_q <= {num_q[TIME_W-2:0], (state_q == D_DIV) ? ge : 1'b0};
			rem_q <= (state_q == D_DIV && last_bit) ? '0 : rem_nx;
		end
	end

endmodule

`default_nettype wire

/* src/htw_front.sv */
// Front end: accepts requests, classifies the mode and queues commands.
// Depends on htw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module htw_front #(
	parameter int TIMERS = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [htw_pkg::S_TDATA_W-1:0]   s_tdata,
	input  wire logic [htw_pkg::MODE_W-1:0]      s_tuser,
	output logic                                 q_valid,
	input  wire logic                            q_ready,
	output htw_pkg::htw_cmd_t                    q_cmd
);
	import htw_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	htw_cmd_t          fifo_q [QDEPTH];
	logic [PW-1:0]     wp_q, rp_q;
	logic [PW:0]       cnt_q;
	htw_cmd_t          cmd_in;
	logic              push, pop;

	always_comb begin
		cmd_in.time_ms   = s_tdata[TIME_W-1:0];
		cmd_in.clock_ms  = s_tdata[2*TIME_W-1:TIME_W];
		cmd_in.handle    = s_tdata[2*TIME_W+HANDLE_W-1:2*TIME_W];
		cmd_in.handle_ok = {1'b0, cmd_in.handle} < 6'(TIMERS);
		unique case (s_tuser)
			MODE_START_REL: cmd_in.op = OP_START_REL;
			MODE_START_ABS: cmd_in.op = OP_START_ABS;
			MODE_STOP:      cmd_in.op = OP_STOP;
			MODE_TICK:      cmd_in.op = OP_TICK;
			default:        cmd_in.op = OP_TICK;
		endcase
	end

	assign s_tready = cnt_q != (PW + 1)'(QDEPTH);
	assign q_valid  = cnt_q != '0;
	assign q_cmd    = fifo_q[rp_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + PW'(1);
			if (pop)  rp_q <= (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + PW'(1);
			cnt_q <= cnt_q + (PW + 1)'(push) - (PW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= cmd_in;
	end

endmodule

`default_nettype wire

/* src/htw_back.sv */
// Back end: sequencer that runs starts, stops and ticks over the timer pool.
// Depends on htw_pkg, htw_ram and htw_div.
`timescale 1ns / 1ps
`default_nettype none

module htw_back #(
	parameter int TIMERS = 32,
	parameter int SLOTS  = 256
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            q_valid,
	output logic                                 q_ready,
	input  wire htw_pkg::htw_cmd_t               q_cmd,
	input  wire logic [htw_pkg::PERIOD_W-1:0]    eff_per,
	input  wire logic [htw_pkg::SCNT_W-1:0]      eff_slots,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [htw_pkg::KIND_W-1:0]      out_kind,
	output logic      [htw_pkg::ID_W-1:0]        out_id,
	output logic      [htw_pkg::TIME_W-1:0]      out_exp,
	output logic                                 out_cu,
	output logic                                 out_last
);
	import htw_pkg::*;

	localparam int IW = $clog2(TIMERS);
	localparam int CW = $clog2(TIMERS + 1);
	localparam int SW = $clog2(SLOTS);
	localparam int RW = TIME_W + SEQ_W + SW;

	htw_back_state_t     state_q, state_nx;
	htw_cmd_t            cmd_q;
	logic [TIMERS-1:0]   valid_q;
	logic [TIME_W-1:0]   wheel_q, exp_q, fire_t_q, best_exp_q;
	logic [SW-1:0]       cs_q, slot_q, target_q, fire_slot_q;
	logic [SEQ_W-1:0]    seq_q, best_seq_q;
	logic [IW-1:0]       free_q, best_idx_q, cmp_idx_s1;
	logic [CW-1:0]       rd_i_q;
	logic                cmp_vld_s1, found_q, behind_q, fire_cu_q;

	logic                out_valid_q, out_cu_q, out_last_q;
	logic [KIND_W-1:0]   out_kind_q;
	logic [ID_W-1:0]     out_id_q;
	logic [TIME_W-1:0]   out_exp_q;

	logic                out_free, all_busy, none_busy, stop_ok, scan_end, cand, better;
	logic                rd_more, inc_fits;
	logic [IW-1:0]       free_idx;
	logic [TIME_W-1:0]   exp_calc, rd_exp;
	logic [SEQ_W-1:0]    rd_seq;
	logic [SW-1:0]       rd_slot;
	logic [SW:0]         cs_inc;
	logic [SCNT_W-1:0]   cs_inc9;

	logic                emit, e_cu, e_last;
	logic [KIND_W-1:0]   e_kind;
	logic [ID_W-1:0]     e_id;
	logic [TIME_W-1:0]   e_exp;
	logic                ram_we, ram_re;
	logic [IW-1:0]       ram_waddr, ram_raddr;
	logic [RW-1:0]       ram_wdata, ram_rdata;
	htw_div_req_t        div_req;
	logic                div_done;
	logic [SW-1:0]       div_res;

	htw_ram #(.WIDTH(RW), .DEPTH(TIMERS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	htw_div #(.SW(SW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.per    (eff_per),
		.slots  (eff_slots),
		.done   (div_done),
		.res    (div_res)
	);

	always_comb begin
		out_free  = !out_valid_q || out_ready;
		all_busy  = &valid_q;
		none_busy = ~|valid_q;
		free_idx  = '0;
		for (int i = TIMERS - 1; i >= 0; i--) begin
			if (!valid_q[i]) free_idx = IW'(i);
		end
		exp_calc = (cmd_q.op == OP_START_REL) ? wheel_q + cmd_q.time_ms : cmd_q.time_ms;
		stop_ok  = cmd_q.handle_ok && valid_q[IW'(cmd_q.handle)];
		rd_exp   = ram_rdata[TIME_W-1:0];
		rd_seq   = ram_rdata[TIME_W+SEQ_W-1:TIME_W];
		rd_slot  = ram_rdata[RW-1:TIME_W+SEQ_W];
		rd_more  = rd_i_q < CW'(TIMERS);
		scan_end = !rd_more && !cmp_vld_s1;
		cand     = valid_q[cmp_idx_s1] && rd_slot == fire_slot_q && rd_exp <= fire_t_q;
		better   = !found_q || rd_exp < best_exp_q ||
		           (rd_exp == best_exp_q && rd_seq < best_seq_q);
		cs_inc   = {1'b0, cs_q} + (SW + 1)'(1);
		cs_inc9  = SCNT_W'(cs_inc);
		inc_fits = cs_inc9 < eff_slots;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					unique case (q_cmd.op)
						OP_START_REL, OP_START_ABS: state_nx = B_START;
						OP_STOP:                    state_nx = B_STOP;
						OP_TICK:                    state_nx = B_TICK;
						default:                    state_nx = B_TICK;
					endcase
				end
			end
			B_START: begin
				if (all_busy)       state_nx = B_ERR_EMIT;
				else if (none_busy) state_nx = B_SYNC_WAIT;
				else                state_nx = B_EXP;
			end
			B_SYNC_WAIT:  if (div_done) state_nx = B_EXP;
			B_EXP:        state_nx = B_EXP_WAIT;
			B_EXP_WAIT:   if (div_done) state_nx = B_START_EMIT;
			B_START_EMIT: if (out_free) state_nx = B_IDLE;
			B_STOP:       state_nx = stop_ok ? B_STOP_EMIT : B_ERR_EMIT;
			B_STOP_EMIT:  if (out_free) state_nx = B_IDLE;
			B_ERR_EMIT:   if (out_free) state_nx = B_IDLE;
			B_TICK:       state_nx = B_SCAN;
			B_SCAN:       if (scan_end) state_nx = B_FIRE;
			B_FIRE: begin
				if (found_q) begin
					if (out_free) state_nx = B_SCAN;
				end else begin
					state_nx = fire_cu_q ? B_SWEEP_ADV : B_TICK_POST;
				end
			end
			B_TICK_POST: begin
				if (cs_q != '0) state_nx = inc_fits ? B_TICK_DONE : B_ADV_WAIT;
				else            state_nx = B_TGT_WAIT;
			end
			B_ADV_WAIT:   if (div_done) state_nx = B_TICK_DONE;
			B_TGT_WAIT:   if (div_done) state_nx = behind_q ? B_SWEEP_CHK : B_TICK_DONE;
			B_SWEEP_CHK:  state_nx = (cs_q != target_q) ? B_SCAN : B_TICK_DONE;
			B_SWEEP_ADV:  state_nx = B_SWEEP_CHK;
			B_TICK_DONE:  if (out_free) state_nx = B_IDLE;
			default:      state_nx = B_IDLE;
		endcase
	end

	always_comb begin
		q_ready          = state_q == B_IDLE;
		emit             = 1'b0;
		e_kind           = KIND_STARTED;
		e_id             = '0;
		e_exp            = '0;
		e_cu             = 1'b0;
		e_last           = 1'b1;
		ram_we           = 1'b0;
		ram_waddr        = free_q;
		ram_wdata        = {slot_q, seq_q, exp_q};
		ram_re           = 1'b0;
		ram_raddr        = IW'(rd_i_q);
		div_req.start    = 1'b0;
		div_req.mod_only = 1'b0;
		div_req.num      = cmd_q.clock_ms;
		unique case (state_q)
			B_START: div_req.start = !all_busy && none_busy;
			B_EXP: begin
				div_req.start = 1'b1;
				div_req.num   = exp_calc;
			end
			B_START_EMIT: begin
				emit   = out_free;
				ram_we = out_free;
				e_id   = ID_W'(free_q);
				e_exp  = exp_q;
			end
			B_STOP: begin
				ram_re    = stop_ok;
				ram_raddr = IW'(cmd_q.handle);
			end
			B_STOP_EMIT: begin
				emit  = out_free;
				e_id  = cmd_q.handle;
				e_exp = rd_exp;
			end
			B_ERR_EMIT: begin
				emit   = out_free;
				e_kind = KIND_ERROR;
				e_id   = (cmd_q.op == OP_STOP) ? cmd_q.handle : '0;
			end
			B_SCAN: ram_re = rd_more;
			B_FIRE: begin
				emit   = found_q && out_free;
				e_kind = KIND_FIRED;
				e_id   = ID_W'(best_idx_q);
				e_exp  = best_exp_q;
				e_cu   = fire_cu_q;
				e_last = 1'b0;
			end
			B_TICK_POST: begin
				if (cs_q != '0) begin
					div_req.start    = !inc_fits;
					div_req.mod_only = 1'b1;
					div_req.num      = TIME_W'(cs_inc);
				end else begin
					div_req.start = 1'b1;
				end
			end
			B_TICK_DONE: begin
				emit   = out_free;
				e_kind = KIND_TICK;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			valid_q     <= '0;
			wheel_q     <= '0;
			cs_q        <= '0;
			seq_q       <= '0;
			rd_i_q      <= '0;
			cmp_vld_s1  <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			out_valid_q <= emit || (out_valid_q && !out_ready);
			case (state_q)
				B_SYNC_WAIT: begin
					if (div_done) begin
						wheel_q <= cmd_q.clock_ms;
						cs_q    <= div_res;
					end
				end
				B_START_EMIT: begin
					if (out_free) begin
						valid_q[free_q] <= 1'b1;
						seq_q           <= seq_q + SEQ_W'(1);
					end
				end
				B_STOP_EMIT: if (out_free) valid_q[IW'(cmd_q.handle)] <= 1'b0;
				B_TICK: begin
					rd_i_q     <= '0;
					cmp_vld_s1 <= 1'b0;
					found_q    <= 1'b0;
				end
				B_SCAN: begin
					cmp_vld_s1 <= rd_more;
					if (rd_more) rd_i_q <= rd_i_q + CW'(1);
					if (cmp_vld_s1 && cand && better) found_q <= 1'b1;
				end
				B_FIRE: begin
					if (found_q && out_free) begin
						valid_q[best_idx_q] <= 1'b0;
						rd_i_q              <= '0;
						cmp_vld_s1          <= 1'b0;
						found_q             <= 1'b0;
					end
				end
				B_TICK_POST: begin
					if (cs_q != '0) begin
						wheel_q <= wheel_q + TIME_W'(eff_per);
						if (inc_fits) cs_q <= SW'(cs_inc);
					end
				end
				B_ADV_WAIT: if (div_done) cs_q <= div_res;
				B_TGT_WAIT: begin
					if (div_done && !behind_q) begin
						cs_q    <= div_res;
						wheel_q <= cmd_q.clock_ms;
					end
				end
				B_SWEEP_CHK: begin
					if (cs_q != target_q) begin
						rd_i_q     <= '0;
						cmp_vld_s1 <= 1'b0;
						found_q    <= 1'b0;
					end else begin
						wheel_q <= cmd_q.clock_ms;
					end
				end
				B_SWEEP_ADV: cs_q <= (cs_inc9 == eff_slots) ? '0 : SW'(cs_inc);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q <= e_kind;
			out_id_q   <= e_id;
			out_exp_q  <= e_exp;
			out_cu_q   <= e_cu;
			out_last_q <= e_last;
		end
		if (state_q == B_IDLE && q_valid) cmd_q <= q_cmd;
		if (state_q == B_START) free_q <= free_idx;
		if (state_q == B_EXP) exp_q <= exp_calc;
		if (state_q == B_EXP_WAIT && div_done) slot_q <= div_res;
		if (state_q == B_SCAN) cmp_idx_s1 <= IW'(rd_i_q);
		if (state_q == B_SCAN && cmp_vld_s1 && cand && better) begin
			best_idx_q <= cmp_idx_s1;
			best_exp_q <= rd_exp;
			best_seq_q <= rd_seq;
		end
		if (state_q == B_TICK) begin
			fire_slot_q <= cs_q;
			fire_t_q    <= wheel_q;
			fire_cu_q   <= 1'b0;
		end
		if (state_q == B_SWEEP_CHK) begin
			fire_slot_q <= cs_q;
			fire_t_q    <= cmd_q.clock_ms;
			fire_cu_q   <= 1'b1;
		end
		// slot 0: behind means the clock ran ahead of the wheel
		if (state_q == B_TICK_POST) behind_q <= wheel_q < cmd_q.clock_ms;
		if (state_q == B_TGT_WAIT && div_done) target_q <= div_res;
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_id    = out_id_q;
	assign out_exp   = out_exp_q;
	assign out_cu    = out_cu_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

/* src/hashed_timer_wheel.sv */
// Top level of the hashed timer wheel: configuration registers and stream ports.
// Depends on htw_pkg, htw_front and htw_back.
`timescale 1ns / 1ps
`default_nettype none

// Hashed timer wheel over a pool of TIMERS timers, times in 40-bit milliseconds.
// Requests enter a two-deep command queue and are run one at a time by a
// sequencer; results leave through an output register, so the front keeps
// accepting while a result waits. A start takes one slot computation (a
// bit-serial divide by the period followed by a bit-serial modulo by the
// slot count), two when the pool was empty. A tick scans the pool once per
// fired timer plus once more, each scan through the single read port of the
// timer RAM; a modulo by the slot count is added when the slot index wraps,
// and at slot 0 it adds one slot computation for the clock and one scan per
// slot swept while catching up.
// Configuration may be written only while the block is idle.
module hashed_timer_wheel #(
	parameter int TIMERS = htw_pkg::TIMERS_DEF,
	parameter int SLOTS  = htw_pkg::SLOTS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// time_ms [39:0], clock_ms [79:40], handle [84:80], zero pad
	input  wire logic [htw_pkg::S_TDATA_W-1:0]   s_tdata,
	// mode [1:0]
	input  wire logic [htw_pkg::MODE_W-1:0]      s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// timer_id [4:0], expiry_ms [44:5], zero pad
	output logic      [htw_pkg::M_TDATA_W-1:0]   m_tdata,
	// kind [1:0], caught_up [2]
	output logic      [htw_pkg::M_TUSER_W-1:0]   m_tuser,
	output logic                                 m_tlast,
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_index,
	input  wire logic [htw_pkg::CFG_W-1:0]       cfg_wdata
);
	import htw_pkg::*;

	logic [PERIOD_W-1:0] period_q, eff_per;
	logic [SCNT_W-1:0]   slots_q, eff_slots;
	logic                q_valid, q_ready;
	htw_cmd_t            q_cmd;
	logic [KIND_W-1:0]   out_kind;
	logic [ID_W-1:0]     out_id;
	logic [TIME_W-1:0]   out_exp;
	logic                out_cu;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			slots_q  <= SLOTS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PERIOD: period_q <= cfg_wdata;
				CFG_SLOTS:  slots_q  <= cfg_wdata[SCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_per = (period_q == '0) ? PERIOD_W'(1) : period_q;
		if (slots_q == '0)                 eff_slots = SCNT_W'(1);
		else if (slots_q > SCNT_W'(SLOTS)) eff_slots = SCNT_W'(SLOTS);
		else                               eff_slots = slots_q;
	end

	htw_front #(.TIMERS(TIMERS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_cmd    (q_cmd)
	);

	htw_back #(.TIMERS(TIMERS), .SLOTS(SLOTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_cmd     (q_cmd),
		.eff_per   (eff_per),
		.eff_slots (eff_slots),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (out_kind),
		.out_id    (out_id),
		.out_exp   (out_exp),
		.out_cu    (out_cu),
		.out_last  (m_tlast)
	);

	assign m_tdata = {(M_TDATA_W - TIME_W - ID_W)'(0), out_exp, out_id};
	assign m_tuser = {out_cu, out_kind};

endmodule

`default_nettype wire

/* src/htw_checker.sv */
// Port-level checks on the result stream of the timer wheel, bound to the top.
// Depends on htw_pkg and hashed_timer_wheel.
`timescale 1ns / 1ps
`default_nettype none

module htw_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [htw_pkg::M_TDATA_W-1:0]   m_tdata,
	input wire logic [htw_pkg::M_TUSER_W-1:0]   m_tuser,
	input wire logic                            m_tlast
);
	import htw_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_tick_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == KIND_TICK |-> m_tlast)
		else $error("tick done is not the final result");

	a_fire_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == KIND_FIRED |-> !m_tlast)
		else $error("fired timer marked final");

	a_cu_fire: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] == KIND_FIRED)
		else $error("caught_up on a result that is not a fire");

	a_zero_exp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == KIND_TICK || m_tuser[1:0] == KIND_ERROR)
		|-> m_tdata[44:5] == '0)
		else $error("expiry not zero on tick done or error");

endmodule

bind hashed_timer_wheel htw_checker u_htw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
